/* design/swtb_pkg.sv */
// shared types and constants of the software timer bank
package swtb_pkg;

   // default bank shape
   localparam int NUM_TIMERS_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 32;

   // request and response field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 3;
   localparam int TICKS_W  = 32;
   localparam int MASK_W   = 8;
   localparam int REQ_BITS = CMD_W + ID_W + TICKS_W + 1;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + ID_W + 1 + 1 + MASK_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_ALLOC      = 3'd1,
      CMD_START      = 3'd2,
      CMD_RESUME     = 3'd3,
      CMD_PAUSE      = 3'd4,
      CMD_RESTART    = 3'd5,
      CMD_QUERY      = 3'd6,
      CMD_READ_CLEAR = 3'd7
   } cmd_type;

   // per-timer control strobes
   typedef struct packed {
      logic tick;
      logic start;
      logic resume;
      logic pause;
      logic restart;
      logic clear_exp;
      logic periodic;
   } chan_ctl_type;

   // per-timer flags seen by the response logic
   typedef struct packed {
      logic running;
      logic expired;
   } chan_stat_type;

endpackage

/* design/swtb_chan.sv */
// one down-counting timer channel
module swtb_chan #(
   parameter int COUNT_WIDTH = swtb_pkg::COUNT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swtb_pkg::chan_ctl_type   ctl,
   input  logic [COUNT_WIDTH-1:0]   load_value,
   output swtb_pkg::chan_stat_type  stat,
   output logic                     expire
);
   import swtb_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic                   running_ff, running_in;
   logic                   expired_ff, expired_in;
   logic                   periodic_ff, periodic_in;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic                   hit;

   assign count_dec = count_ff - COUNT_WIDTH'(1);
   assign hit       = (count_dec == '0);
   assign expire    = ctl.tick && running_ff && hit;

   always_comb begin
      count_in    = count_ff;
      period_in   = period_ff;
      running_in  = running_ff;
      expired_in  = expired_ff;
      periodic_in = periodic_ff;
      if (ctl.tick && running_ff) begin
         count_in = count_dec;
         if (hit) begin
            expired_in = 1'b1;
            if (periodic_ff) begin
               count_in = period_ff;
            end else begin
               running_in = 1'b0;
            end
         end
      end
      if (ctl.start) begin
         period_in   = load_value;
         count_in    = load_value;
         periodic_in = ctl.periodic;
         expired_in  = 1'b0;
         running_in  = 1'b1;
      end
      // resume only wakes a stopped timer
      if (ctl.resume && !running_ff) begin
         count_in   = period_ff;
         running_in = 1'b1;
      end
      if (ctl.pause) begin
         running_in = 1'b0;
         expired_in = 1'b0;
      end
      if (ctl.restart) begin
         count_in   = period_ff;
         expired_in = 1'b0;
         running_in = 1'b1;
      end
      if (ctl.clear_exp) begin
         expired_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         period_ff   <= '0;
         running_ff  <= 1'b0;
         expired_ff  <= 1'b0;
         periodic_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         period_ff   <= period_in;
         running_ff  <= running_in;
         expired_ff  <= expired_in;
         periodic_ff <= periodic_in;
      end
   end

   assign stat.running = running_ff;
   assign stat.expired = expired_ff;

endmodule

/* design/software_timer_bank.sv */
// top level of the software timer bank: request register, command decode, response register
// a request is held in the request register, then its response in the response register
// throughput: one request per cycle; every timer updates in parallel in the decode cycle
// a stalled response holds the pipe, req_tready drops once both stages are full
// reset (synchronous, active high) stops all timers, clears counts, periods and flags
// and frees every timer id
module software_timer_bank #(
   parameter int NUM_TIMERS  = swtb_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = swtb_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // command[2:0], timer_id[5:3], ticks[37:6], periodic[38], zero fill above
   input  logic [swtb_pkg::REQ_W-1:0] req_tdata,
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // accepted[0], allocated_id[3:1], running_flag[4], expired_flag[5],
   // expiry_mask[13:6], zero fill above
   output logic [swtb_pkg::RSP_W-1:0] rsp_tdata
);
   import swtb_pkg::*;

   // allocation counter must hold NUM_TIMERS itself
   localparam int AC_W = $clog2(NUM_TIMERS + 1);

   // request register stage
   logic                   req_valid_ff;
   cmd_type                cmd_ff;
   logic [ID_W-1:0]        id_ff;
   logic [TICKS_W-1:0]     ticks_ff;
   logic                   periodic_ff;

   // response register stage
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [AC_W-1:0]        alloc_count_ff, alloc_count_in;

   logic                   advance;
   logic [7:0]             id_ext;
   logic [7:0]             ac_ext;
   logic                   in_bank;
   logic                   id_valid;
   logic                   alloc_ok;
   logic [AC_W+ID_W-1:0]   ac_pad;
   logic [TICKS_W+COUNT_WIDTH-1:0] ticks_pad;
   logic [COUNT_WIDTH-1:0] load_value;

   chan_ctl_type           ctl   [NUM_TIMERS];
   chan_stat_type          stat  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  expire_vec;
   logic [NUM_TIMERS-1:0]  running_vec;
   logic [NUM_TIMERS-1:0]  expired_vec;
   logic [NUM_TIMERS-1:0]  sel_vec;
   logic [NUM_TIMERS+MASK_W-1:0] mask_pad;

   // response fields
   logic                   r_accepted;
   logic [ID_W-1:0]        r_alloc_id;
   logic                   r_running;
   logic                   r_expired;
   logic [MASK_W-1:0]      r_mask;

   // the decode stage moves whenever the response register is free or being drained
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign id_ext   = 8'(id_ff);
   assign ac_ext   = 8'(alloc_count_ff);
   assign in_bank  = (id_ext < 8'(NUM_TIMERS));
   assign id_valid = in_bank && (id_ext < ac_ext);
   assign alloc_ok = (alloc_count_ff < AC_W'(NUM_TIMERS));
   assign ac_pad   = {{ID_W{1'b0}}, alloc_count_ff};

   // ticks keeps only the low COUNT_WIDTH bits, zero extended when the counter is wider
   assign ticks_pad  = {{COUNT_WIDTH{1'b0}}, ticks_ff};
   assign load_value = ticks_pad[COUNT_WIDTH-1:0];

   // per-timer decode of the current request
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         sel_vec[i]         = in_bank && (id_ext == 8'(i));
         ctl[i]             = '0;
         ctl[i].periodic    = periodic_ff;
         ctl[i].tick        = advance && (cmd_ff == CMD_TICK);
         ctl[i].start       = advance && (cmd_ff == CMD_START) && id_valid && sel_vec[i];
         ctl[i].resume      = advance && (cmd_ff == CMD_RESUME) && id_valid && sel_vec[i];
         ctl[i].pause       = advance && (cmd_ff == CMD_PAUSE) && id_valid && sel_vec[i];
         ctl[i].restart     = advance && (cmd_ff == CMD_RESTART) && id_valid && sel_vec[i];
         // read-clear acts on unallocated ids too, their flag is already low
         ctl[i].clear_exp   = advance && (cmd_ff == CMD_READ_CLEAR) && sel_vec[i];
         running_vec[i]     = stat[i].running;
         expired_vec[i]     = stat[i].expired;
      end
   end

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chan
      swtb_chan #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .load_value (load_value),
         .stat       (stat[g]),
         .expire     (expire_vec[g])
      );
   end

   // only timers 0..7 reach the expiry mask
   assign mask_pad = {{MASK_W{1'b0}}, expire_vec};

   // response fields and the allocation counter
   always_comb begin
      r_accepted     = 1'b0;
      r_alloc_id     = '0;
      r_running      = 1'b0;
      r_expired      = 1'b0;
      r_mask         = '0;
      alloc_count_in = alloc_count_ff;
      unique case (cmd_ff)
         CMD_TICK: begin
            r_accepted = 1'b1;
            r_mask     = mask_pad[MASK_W-1:0];
         end
         CMD_ALLOC: begin
            if (alloc_ok) begin
               r_accepted = 1'b1;
               r_alloc_id = ac_pad[ID_W-1:0];
               if (advance) begin
                  alloc_count_in = alloc_count_ff + AC_W'(1);
               end
            end
         end
         CMD_START, CMD_RESUME, CMD_PAUSE, CMD_RESTART: begin
            r_accepted = id_valid;
         end
         CMD_QUERY: begin
            r_accepted = id_valid;
            r_running  = |(running_vec & sel_vec);
         end
         CMD_READ_CLEAR: begin
            r_accepted = id_valid;
            r_expired  = |(expired_vec & sel_vec);
         end
      endcase
      rsp_data_in = RSP_W'({r_mask, r_expired, r_running, r_alloc_id, r_accepted});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         alloc_count_ff <= '0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         alloc_count_ff <= alloc_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff      <= cmd_type'(req_tdata[CMD_W-1:0]);
         id_ff       <= req_tdata[CMD_W+ID_W-1:CMD_W];
         ticks_ff    <= req_tdata[CMD_W+ID_W+TICKS_W-1:CMD_W+ID_W];
         periodic_ff <= req_tdata[CMD_W+ID_W+TICKS_W];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/swtb_checker.sv */
// port-level checks of the software timer bank and their bind
module swtb_port_checks (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [swtb_pkg::RSP_W-1:0] rsp_tdata
);
   import swtb_pkg::*;

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an expiry mask only comes from a tick, which is always accepted
   a_mask_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[13:6] != 8'd0) |-> rsp_tdata[0])
      else $error("expiry mask on a rejected response");

   // a handed-out id is only reported with accepted set
   a_alloc_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] != 3'd0) |-> rsp_tdata[0])
      else $error("allocated id on a rejected response");

   // each command fills at most one kind of result field
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[4], rsp_tdata[5], |rsp_tdata[13:6], |rsp_tdata[3:1]}))
      else $error("response mixes result fields of different commands");

endmodule

bind software_timer_bank swtb_port_checks u_swtb_port_checks (.*);

/* sim/swtb_checker.sv */
// checker for the software timer bank: tracks every timer and compares each response
module swtb_checker #(
   parameter int NUM_TIMERS  = swtb_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = swtb_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // command[2:0], timer_id[5:3], ticks[37:6], periodic[38], zero fill above
   input  logic [swtb_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // accepted[0], allocated_id[3:1], running_flag[4], expired_flag[5],
   // expiry_mask[13:6], zero fill above
   input  logic [swtb_pkg::RSP_W-1:0] rsp_tdata,
   output int                         mismatch_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import swtb_pkg::*;

   typedef struct packed {
      logic              accepted;
      logic [ID_W-1:0]   allocated_id;
      logic              running_flag;
      logic              expired_flag;
      logic [MASK_W-1:0] expiry_mask;
   } timer_rsp_type;

   logic [COUNT_WIDTH-1:0] period_mem [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] count_mem  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  running_vec;
   logic [NUM_TIMERS-1:0]  expired_vec;
   logic [NUM_TIMERS-1:0]  periodic_vec;
   int unsigned            timers_allocated;
   timer_rsp_type          awaited_rsps [$];
   int                     fail_total;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      fail_total     = 0;
   end

   // apply one request to the bank copy and return the response it should give
   function automatic timer_rsp_type apply_command(input logic [REQ_W-1:0] raw);
      cmd_type                cmd;
      int unsigned            id;
      logic [COUNT_WIDTH-1:0] load;
      logic                   per;
      logic                   in_bank;
      logic                   owned;
      timer_rsp_type          r;
      cmd     = cmd_type'(raw[2:0]);
      id      = 32'(raw[5:3]);
      load    = COUNT_WIDTH'(raw[37:6]);
      per     = raw[38];
      in_bank = id < NUM_TIMERS;
      owned   = in_bank && id < timers_allocated;
      r       = '0;
      case (cmd)
         CMD_TICK: begin
            r.accepted = 1'b1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (i < timers_allocated && running_vec[i]) begin
                  count_mem[i] = count_mem[i] - COUNT_WIDTH'(1);
                  if (count_mem[i] == '0) begin
                     expired_vec[i] = 1'b1;
                     if (periodic_vec[i]) begin
                        count_mem[i] = period_mem[i];
                     end else begin
                        running_vec[i] = 1'b0;
                     end
                     if (i < MASK_W) r.expiry_mask[i] = 1'b1;
                  end
               end
            end
         end
         CMD_ALLOC: begin
            if (timers_allocated < NUM_TIMERS) begin
               r.allocated_id   = ID_W'(timers_allocated);
               r.accepted       = 1'b1;
               timers_allocated = timers_allocated + 1;
            end
         end
         CMD_START: begin
            if (owned) begin
               period_mem[id]   = load;
               count_mem[id]    = load;
               periodic_vec[id] = per;
               expired_vec[id]  = 1'b0;
               running_vec[id]  = 1'b1;
               r.accepted       = 1'b1;
            end
         end
         CMD_RESUME: begin
            if (owned) begin
               if (!running_vec[id]) begin
                  count_mem[id]   = period_mem[id];
                  running_vec[id] = 1'b1;
               end
               r.accepted = 1'b1;
            end
         end
         CMD_PAUSE: begin
            if (owned) begin
               running_vec[id] = 1'b0;
               expired_vec[id] = 1'b0;
               r.accepted      = 1'b1;
            end
         end
         CMD_RESTART: begin
            if (owned) begin
               count_mem[id]   = period_mem[id];
               expired_vec[id] = 1'b0;
               running_vec[id] = 1'b1;
               r.accepted      = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (in_bank) begin
               r.running_flag = running_vec[id];
               r.accepted     = owned;
            end
         end
         default: begin
            if (in_bank) begin
               r.expired_flag  = expired_vec[id];
               expired_vec[id] = 1'b0;
               r.accepted      = owned;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      timer_rsp_type seen;
      timer_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            period_mem[i] = '0;
            count_mem[i]  = '0;
         end
         running_vec      = '0;
         expired_vec      = '0;
         periodic_vec     = '0;
         timers_allocated = 0;
         awaited_rsps.delete();
      end else begin
         if (req_tvalid && req_tready) awaited_rsps.push_back(apply_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen.accepted     = rsp_tdata[0];
            seen.allocated_id = rsp_tdata[3:1];
            seen.running_flag = rsp_tdata[4];
            seen.expired_flag = rsp_tdata[5];
            seen.expiry_mask  = rsp_tdata[13:6];
            if (awaited_rsps.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: response with none outstanding: data %h", $realtime, rsp_tdata);
               fail_total++;
            end else begin
               want = awaited_rsps.pop_front();
               if (seen.accepted != want.accepted || seen.allocated_id != want.allocated_id ||
                   seen.running_flag != want.running_flag ||
                   seen.expired_flag != want.expired_flag ||
                   seen.expiry_mask != want.expiry_mask) begin
                  if (fail_total < 10)
                     $display({"%0t: response mismatch: expected acc %0d id %0d run %0d ",
                               "exp %0d mask %h, got acc %0d id %0d run %0d exp %0d mask %h"},
                              $realtime, want.accepted, want.allocated_id, want.running_flag,
                              want.expired_flag, want.expiry_mask, seen.accepted,
                              seen.allocated_id, seen.running_flag, seen.expired_flag,
                              seen.expiry_mask);
                  fail_total++;
               end
            end
         end
      end
      pending_count  <= awaited_rsps.size();
      mismatch_count <= fail_total;
   end

endmodule

/* sim/tb_top.sv */
// testbench top for the software timer bank: clock, reset, request stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swtb_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int CALM_ITEMS   = 150;   // final stretch with no idling on either side
   localparam int HOLD_AT      = 500;   // random request index that triggers the long stall
   localparam int HOLD_CYCLES  = 400;   // length of the long response stall

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // command[2:0], timer_id[5:3], ticks[37:6], periodic[38], zero fill above
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // accepted[0], allocated_id[3:1], running_flag[4], expired_flag[5],
   // expiry_mask[13:6], zero fill above
   logic [RSP_W-1:0] rsp_tdata;

   int mismatch_count;
   int pending_count;

   // shared between the request process and the response process
   bit calm_tail;
   bit hold_off_pending;

   software_timer_bank u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swtb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs or a response never shows up
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // offer one request from a falling edge and hold it until the block takes it,
   // then maybe leave the channel idle for a burst of cycles
   task automatic issue_command(input cmd_type cmd, input logic [ID_W-1:0] id,
                                input logic [TICKS_W-1:0] ticks, input logic per);
      req_tdata  = REQ_W'({per, ticks, id, cmd});
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   // response side: ready and stall stretches, one long stall on request,
   // always ready once the calm tail begins
   initial begin
      int  run_left;
      bit  run_ready;
      run_left   = 0;
      run_ready  = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            if (calm_tail) begin
               run_ready = 1'b1;
               run_left  = 1;
            end else if (hold_off_pending) begin
               // stall long enough for the pipe to fill and req_tready to drop
               hold_off_pending = 1'b0;
               run_ready        = 1'b0;
               run_left         = HOLD_CYCLES;
            end else begin
               run_ready = $urandom_range(0, 2) != 0;
               run_left  = run_ready ? int'($urandom_range(1, 30)) : int'($urandom_range(1, 19));
            end
         end
         rsp_tready = run_ready;
         run_left--;
      end
   end

   // request stimulus and verdict
   initial begin
      cmd_type           cmd;
      logic [ID_W-1:0]   id;
      logic [TICKS_W-1:0] ticks;
      logic              per;
      int                pick;
      int                span;

      req_tvalid       = 1'b0;
      req_tdata        = '0;
      calm_tail        = 1'b0;
      hold_off_pending = 1'b0;
      reset            = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // nothing allocated yet: empty tick, then control and queries on free ids
      issue_command(CMD_TICK,       3'd0, 32'd0,         1'b0);
      issue_command(CMD_START,      3'd3, 32'd5,         1'b1);
      issue_command(CMD_RESUME,     3'd0, 32'd0,         1'b0);
      issue_command(CMD_PAUSE,      3'd1, 32'd0,         1'b0);
      issue_command(CMD_RESTART,    3'd2, 32'd0,         1'b0);
      issue_command(CMD_QUERY,      3'd7, 32'd0,         1'b0);
      issue_command(CMD_READ_CLEAR, 3'd7, 32'hFFFF_FFFF, 1'b1);

      // fill the bank, the last allocate finds it full and is rejected
      repeat (NUM_TIMERS_DEF + 1) issue_command(CMD_ALLOC, 3'd0, 32'd0, 1'b0);

      // single shot expiring on the first tick, periodic every second tick,
      // zero count that wraps, and the largest period
      issue_command(CMD_START,      3'd0, 32'd1,         1'b0);
      issue_command(CMD_START,      3'd1, 32'd2,         1'b1);
      issue_command(CMD_START,      3'd2, 32'd0,         1'b1);
      issue_command(CMD_START,      3'd7, 32'hFFFF_FFFF, 1'b0);
      repeat (2) issue_command(CMD_TICK, 3'd0, 32'd0, 1'b0);

      // stopped single shot, read-clear of a set flag, pause/resume/restart
      issue_command(CMD_QUERY,      3'd0, 32'd0,         1'b0);
      issue_command(CMD_READ_CLEAR, 3'd0, 32'd0,         1'b0);
      issue_command(CMD_PAUSE,      3'd1, 32'd0,         1'b0);
      issue_command(CMD_RESUME,     3'd1, 32'd0,         1'b0);
      issue_command(CMD_RESTART,    3'd2, 32'd0,         1'b0);
      issue_command(CMD_TICK,       3'd0, 32'd0,         1'b0);

      // random part: heavy on ticks and short periods so timers keep expiring
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT) hold_off_pending = 1'b1;
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
         pick  = $urandom_range(0, 99);
         id    = ID_W'($urandom_range(0, 7));
         ticks = $urandom();
         per   = 1'($urandom_range(0, 1));
         if (pick < 35) begin
            cmd = CMD_TICK;
         end else if (pick < 37) begin
            cmd = CMD_ALLOC;
         end else if (pick < 56) begin
            cmd  = CMD_START;
            span = $urandom_range(0, 19);
            // mostly short periods, sometimes medium, zero, all ones or any value
            if (span < 13) begin
               ticks = $urandom_range(1, 6);
            end else if (span < 15) begin
               ticks = $urandom_range(7, 40);
            end else if (span == 17) begin
               ticks = '0;
            end else if (span == 18) begin
               ticks = '1;
            end
         end else if (pick < 63) begin
            cmd = CMD_RESUME;
         end else if (pick < 70) begin
            cmd = CMD_PAUSE;
         end else if (pick < 77) begin
            cmd = CMD_RESTART;
         end else if (pick < 86) begin
            cmd = CMD_QUERY;
         end else begin
            cmd = CMD_READ_CLEAR;
         end
         issue_command(cmd, id, ticks, per);
      end
      req_tvalid = 1'b0;

      // drain: every response in, then wait to catch strays
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
